[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the RTL assertions.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rsb_pkg.sv]
// ---------------------------------------------------------------------------
// rsb_pkg
// Widths, constants and shared types of the regularized Stokeslet block.
// ---------------------------------------------------------------------------
`default_nettype none

package rsb_pkg;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 32;
  localparam int SQ_W    = 52;
  localparam int R2_W    = 54;
  localparam int EPS_W   = 48;
  localparam int D_W     = 54;
  localparam int N_W     = 55;
  localparam int ROOT_W  = 32;
  localparam int SQIN_W  = 64;
  localparam int MUL_W   = 64;
  localparam int PROD_W  = 128;
  localparam int DEN_W   = 93;
  localparam int NUM_W   = 111;
  localparam int Q_W     = 48;
  localparam int OUT_W   = 48;
  localparam int NAX     = 3;
  localparam int NE      = 6;

  localparam logic [55:0]      INV8PI    = 56'd45873289113781267;
  localparam logic [EPS_W-1:0] EPS_RESET = 48'd281;
  localparam logic [OUT_W-1:0] POS_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] NEG_MIN   = 48'h8000_0000_0000;

  typedef struct packed {
    logic [NAX-1:0] neg;
    logic [NAX-1:0] off_zero;
    logic           d_zero;
  } rsb_flags_t;

  typedef struct packed {
    logic [D_W-1:0]          d;
    logic [NE-1:0][N_W-1:0]  n;
    rsb_flags_t              flags;
  } rsb_front_t;

endpackage

`default_nettype wire

[rtl/rsb_front.sv]
// ---------------------------------------------------------------------------
// rsb_front
// Four-stage front end: differences, squares, squared distance, numerators.
// ---------------------------------------------------------------------------
`default_nettype none

module rsb_front
  import rsb_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          valid_in,
  input  wire logic [NAX-1:0][COORD_W-1:0]   target,
  input  wire logic [NAX-1:0][COORD_W-1:0]   source,
  input  wire logic [EPS_W-1:0]              eps,
  output logic                               valid_out,
  output rsb_front_t                         front_out
);

  localparam int PA [NAX] = '{0, 0, 1};
  localparam int PB [NAX] = '{1, 2, 2};

  logic [3:0]                 vld_r;
  logic [NAX-1:0][MAG_W-1:0]  mag1_r;
  logic [NAX-1:0]             neg1_r;
  logic [NAX-1:0][SQ_W-1:0]   sq2_r, sq3_r;
  logic [NAX-1:0][SQ_W-1:0]   mm2_r, mm3_r;
  logic [NAX-1:0]             oneg2_r, oneg3_r;
  logic [R2_W-1:0]            r2_3_r;
  rsb_front_t                 front_r;

  logic [NAX-1:0][MAG_W-1:0]  mag1_nxt;
  logic [NAX-1:0]             neg1_nxt;
  logic [NAX-1:0][SQ_W-1:0]   sq2_nxt, mm2_nxt;
  rsb_front_t                 front_nxt;

  always_comb begin
    logic signed [COORD_W:0] r;
    logic [63:0]             p;
    for (int i = 0; i < NAX; i++) begin
      r = $signed({target[i][COORD_W-1], target[i]}) -
          $signed({source[i][COORD_W-1], source[i]});
      neg1_nxt[i] = r[COORD_W];
      mag1_nxt[i] = r[COORD_W] ? MAG_W'(-r) : r[MAG_W-1:0];
    end
    for (int i = 0; i < NAX; i++) begin
      p = 64'(mag1_r[i]) * 64'(mag1_r[i]);
      sq2_nxt[i] = p[63:12];
      p = 64'(mag1_r[PA[i]]) * 64'(mag1_r[PB[i]]);
      mm2_nxt[i] = p[63:12];
    end
  end

  always_comb begin
    logic [D_W:0] dsum;
    dsum = (D_W+1)'(r2_3_r) + (D_W+1)'(eps);
    front_nxt.d = dsum[D_W-1:0];
    front_nxt.flags.d_zero = (dsum == '0);
    for (int i = 0; i < NAX; i++) begin
      front_nxt.n[i] = N_W'(r2_3_r) + N_W'({eps, 1'b0}) + N_W'(sq3_r[i]);
      front_nxt.n[NAX+i] = N_W'(mm3_r[i]);
      front_nxt.flags.off_zero[i] = (mm3_r[i] == '0);
      front_nxt.flags.neg[i] = oneg3_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag1_nxt;
      neg1_r  <= neg1_nxt;
      sq2_r   <= sq2_nxt;
      mm2_r   <= mm2_nxt;
      for (int i = 0; i < NAX; i++) begin
        oneg2_r[i] <= neg1_r[PA[i]] ^ neg1_r[PB[i]];
      end
      sq3_r   <= sq2_r;
      mm3_r   <= mm2_r;
      oneg3_r <= oneg2_r;
      r2_3_r  <= R2_W'(sq2_r[0]) + R2_W'(sq2_r[1]) + R2_W'(sq2_r[2]);
      front_r <= front_nxt;
    end
  end

  assign valid_out = vld_r[3];
  assign front_out = front_r;

endmodule

`default_nettype wire

[rtl/rsb_sqrt.sv]
// ---------------------------------------------------------------------------
// rsb_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ---------------------------------------------------------------------------
`default_nettype none

module rsb_sqrt
  import rsb_pkg::*;
#(
  parameter int SIDE_W = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                valid_in,
  input  wire logic [SQIN_W-1:0]   value,
  input  wire logic [SIDE_W-1:0]   side_in,
  output logic                     valid_out,
  output logic [ROOT_W-1:0]        root,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int NS    = ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]  rem_r  [NS];
  logic [ROOT_W-1:0] root_r [NS];
  logic [SQIN_W-1:0] val_r  [NS];
  logic [SIDE_W-1:0] side_r [NS];
  logic [NS-1:0]     vld_r;

  for (genvar k = 0; k < NS; k++) begin : g_stg
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SQIN_W-1:0] val_in;
    logic [SIDE_W-1:0] side_st;
    logic              vld_in;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  test;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign val_in  = value;
      assign side_st = side_in;
      assign vld_in  = valid_in;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign val_in  = val_r[k-1];
      assign side_st = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    assign trial = {rem_in, val_in[SQIN_W-1 -: 2]};
    assign test  = (REM_W+2)'({root_in, 2'b01});
    assign ge    = (trial >= test);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? REM_W'(trial - test) : trial[REM_W-1:0];
        root_r[k] <= {root_in[ROOT_W-2:0], ge};
        val_r[k]  <= {val_in[SQIN_W-3:0], 2'b00};
        side_r[k] <= side_st;
      end
    end
  end

  assign valid_out = vld_r[NS-1];
  assign root      = root_r[NS-1];
  assign side_out  = side_r[NS-1];

endmodule

`default_nettype wire

[rtl/rsb_mul.sv]
// ---------------------------------------------------------------------------
// rsb_mul
// Two-stage 64x64 multiplier lanes built from 32x32 partial products.
// ---------------------------------------------------------------------------
`default_nettype none

module rsb_mul
  import rsb_pkg::*;
#(
  parameter int LANES  = 7,
  parameter int SIDE_W = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          valid_in,
  input  wire logic [LANES-1:0][MUL_W-1:0]   a,
  input  wire logic [LANES-1:0][MUL_W-1:0]   b,
  input  wire logic [SIDE_W-1:0]             side_in,
  output logic                               valid_out,
  output logic [LANES-1:0][PROD_W-1:0]       p,
  output logic [SIDE_W-1:0]                  side_out
);

  localparam int HW = MUL_W / 2;

  logic [LANES-1:0][MUL_W-1:0]  pp00_r, pp01_r, pp10_r, pp11_r;
  logic [LANES-1:0][PROD_W-1:0] p_r;
  logic [SIDE_W-1:0]            side1_r, side2_r;
  logic [1:0]                   vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        pp00_r[i] <= MUL_W'(a[i][HW-1:0]) * MUL_W'(b[i][HW-1:0]);
        pp01_r[i] <= MUL_W'(a[i][HW-1:0]) * MUL_W'(b[i][MUL_W-1:HW]);
        pp10_r[i] <= MUL_W'(a[i][MUL_W-1:HW]) * MUL_W'(b[i][HW-1:0]);
        pp11_r[i] <= MUL_W'(a[i][MUL_W-1:HW]) * MUL_W'(b[i][MUL_W-1:HW]);
        p_r[i]    <= PROD_W'(pp00_r[i]) + (PROD_W'(pp01_r[i]) << HW) +
                     (PROD_W'(pp10_r[i]) << HW) + (PROD_W'(pp11_r[i]) << MUL_W);
      end
      side1_r <= side_in;
      side2_r <= side1_r;
    end
  end

  assign valid_out = vld_r[1];
  assign p         = p_r;
  assign side_out  = side2_r;

endmodule

`default_nettype wire

[rtl/rsb_div.sv]
// ---------------------------------------------------------------------------
// rsb_div
// Pipelined restoring divider lanes sharing one divisor, one quotient bit
// per stage past the first, with an overflow flag for quotients >= 2^48.
// ---------------------------------------------------------------------------
`default_nettype none

module rsb_div
  import rsb_pkg::*;
#(
  parameter int LANES  = 6,
  parameter int SIDE_W = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          valid_in,
  input  wire logic [LANES-1:0][NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]              den,
  input  wire logic [SIDE_W-1:0]             side_in,
  output logic                               valid_out,
  output logic [LANES-1:0][Q_W-1:0]          q,
  output logic [LANES-1:0]                   ovf,
  output logic [SIDE_W-1:0]                  side_out
);

  localparam int NS   = Q_W + 1;
  localparam int HI_W = NUM_W - Q_W;

  logic [LANES-1:0][DEN_W-1:0] rem_r [NS];
  logic [LANES-1:0][Q_W-1:0]   low_r [NS];
  logic [LANES-1:0][Q_W-1:0]   q_r   [NS];
  logic [LANES-1:0]            ovf_r [NS];
  logic [DEN_W-1:0]            den_r [NS];
  logic [SIDE_W-1:0]           side_r[NS];
  logic [NS-1:0]               vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        rem_r[0][i] <= DEN_W'(num[i][NUM_W-1:Q_W]);
        low_r[0][i] <= num[i][Q_W-1:0];
        q_r[0][i]   <= '0;
        ovf_r[0][i] <= (DEN_W'(num[i][NUM_W-1:Q_W]) >= den);
      end
      den_r[0]  <= den;
      side_r[0] <= side_in;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_stg
    always_ff @(posedge clk) begin
      logic [DEN_W:0] trial;
      if (en) begin
        for (int i = 0; i < LANES; i++) begin
          trial = {rem_r[k-1][i], low_r[k-1][i][Q_W-1]};
          if (trial >= {1'b0, den_r[k-1]}) begin
            rem_r[k][i] <= DEN_W'(trial - {1'b0, den_r[k-1]});
            q_r[k][i]   <= {q_r[k-1][i][Q_W-2:0], 1'b1};
          end else begin
            rem_r[k][i] <= trial[DEN_W-1:0];
            q_r[k][i]   <= {q_r[k-1][i][Q_W-2:0], 1'b0};
          end
          low_r[k][i] <= {low_r[k-1][i][Q_W-2:0], 1'b0};
        end
        ovf_r[k]  <= ovf_r[k-1];
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign valid_out = vld_r[NS-1];
  assign q         = q_r[NS-1];
  assign ovf       = ovf_r[NS-1];
  assign side_out  = side_r[NS-1];

endmodule

`default_nettype wire

[rtl/regularized_stokeslet_block.sv]
// ---------------------------------------------------------------------------
// regularized_stokeslet_block
// Streams point pairs in and the six entries of the regularized Stokeslet
// tensor out, one pair per clock while the output is not stalled.
// ---------------------------------------------------------------------------
// Each request on the in_ channel carries a target and a source point in
// Q2.30; each request on the out_ channel carries s_xx, s_yy, s_zz, s_xy,
// s_xz and s_yz in saturated Q24.24. Results leave in request order.
// The pipeline takes one request per clock while the output is not stalled
// and holds up to 88 of them: 4 front-end stages, 32 square root stages,
// 2 multiplier stages, 49 divider stages and the output register. The
// 49-stage divider sets the depth; the throughput is one request per cycle
// when no result is stalled. The cfg_ channel writes eps_squared and is
// always ready; write it only while no request is in flight. Reset sets
// eps_squared to 281 and empties the pipeline. When the receiver stalls a
// valid result, the whole pipeline holds and in_tready drops until the
// result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module regularized_stokeslet_block
  import rsb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // target_x, target_y, target_z, source_x, source_y, source_z
  input  wire logic [191:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // s_xx, s_yy, s_zz, s_xy, s_xz, s_yz
  output logic [287:0]       out_tdata,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [47:0]   cfg_data
);

  localparam int FRONT_W = $bits(rsb_front_t);
  localparam int FLAG_W  = $bits(rsb_flags_t);
  localparam int LANES   = NE + 1;

  logic [EPS_W-1:0]            eps_r;
  logic                        adv;
  logic                        fr_valid, sq_valid, mul_valid, div_valid;
  rsb_front_t                  fr_data, sq_side;
  logic [ROOT_W-1:0]           root;
  logic [LANES-1:0][MUL_W-1:0] mul_a, mul_b;
  logic [LANES-1:0][PROD_W-1:0] mul_p;
  rsb_flags_t                  mul_flags, div_flags;
  logic [NE-1:0][NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]            div_den;
  logic [NE-1:0][Q_W-1:0]      div_q;
  logic [NE-1:0]               div_ovf;
  logic [NE-1:0][OUT_W-1:0]    res_nxt;
  logic [NE-1:0][OUT_W-1:0]    out_data_r;
  logic                        out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  rsb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .valid_in  (in_tvalid),
    .target    (in_tdata[95:0]),
    .source    (in_tdata[191:96]),
    .eps       (eps_r),
    .valid_out (fr_valid),
    .front_out (fr_data)
  );

  rsb_sqrt #(
    .SIDE_W (FRONT_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .valid_in  (fr_valid),
    .value     ({fr_data.d, 10'b0}),
    .side_in   (fr_data),
    .valid_out (sq_valid),
    .root      (root),
    .side_out  (sq_side)
  );

  always_comb begin
    mul_a[0] = MUL_W'(sq_side.d);
    mul_b[0] = MUL_W'(root);
    for (int i = 0; i < NE; i++) begin
      mul_a[i+1] = MUL_W'(sq_side.n[i]);
      mul_b[i+1] = MUL_W'(INV8PI);
    end
  end

  rsb_mul #(
    .LANES  (LANES),
    .SIDE_W (FLAG_W)
  ) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .valid_in  (sq_valid),
    .a         (mul_a),
    .b         (mul_b),
    .side_in   (sq_side.flags),
    .valid_out (mul_valid),
    .p         (mul_p),
    .side_out  (mul_flags)
  );

  always_comb begin
    div_den = {mul_p[0][DEN_W-8:0], 7'b0};
    for (int i = 0; i < NE; i++) begin
      div_num[i] = mul_p[i+1][NUM_W-1:0];
    end
  end

  rsb_div #(
    .LANES  (NE),
    .SIDE_W (FLAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .valid_in  (mul_valid),
    .num       (div_num),
    .den       (div_den),
    .side_in   (mul_flags),
    .valid_out (div_valid),
    .q         (div_q),
    .ovf       (div_ovf),
    .side_out  (div_flags)
  );

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      if (div_flags.d_zero || div_ovf[i] || (div_q[i] > POS_MAX)) begin
        res_nxt[i] = POS_MAX;
      end else begin
        res_nxt[i] = div_q[i];
      end
      if (div_flags.d_zero || div_flags.off_zero[i]) begin
        res_nxt[NAX+i] = '0;
      end else if (div_flags.neg[i]) begin
        if (div_ovf[NAX+i] || (div_q[NAX+i] > NEG_MIN)) begin
          res_nxt[NAX+i] = NEG_MIN;
        end else begin
          res_nxt[NAX+i] = OUT_W'(-div_q[NAX+i]);
        end
      end else if (div_ovf[NAX+i] || (div_q[NAX+i] > POS_MAX)) begin
        res_nxt[NAX+i] = POS_MAX;
      end else begin
        res_nxt[NAX+i] = div_q[NAX+i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "output valid after reset")
  `ASSERT_CLK(a_diag_nonneg, out_tvalid |-> (!out_tdata[47] && !out_tdata[95] && !out_tdata[143]), "negative diagonal entry")
  `ASSERT_CLK(a_stall_blocks, (out_tvalid && !out_tready) |-> !in_tready, "request taken during output stall")

endmodule

`default_nettype wire

[tb/sv/regularized_stokeslet_block_tb.sv]
// ---------------------------------------------------------------------------
// regularized_stokeslet_block_tb
// Streams point pairs through the Stokeslet block under several regularization
// settings and idle patterns, and compares every tensor entry with a
// bit-exact fixed-point prediction computed in the testbench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module regularized_stokeslet_block_tb;

  localparam int LATENCY = 87;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [47:0] yz;
    logic [47:0] xz;
    logic [47:0] xy;
    logic [47:0] zz;
    logic [47:0] yy;
    logic [47:0] xx;
  } tensor_t;

  class tensor_scoreboard;
    tensor_t pending[$];
    int errors;
    logic [47:0] eps2;

    function new();
      errors = 0;
      eps2 = 48'd281;
    endfunction

    static function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    static function logic [47:0] entry_of(logic [63:0] mag, bit neg, logic [127:0] den);
      logic [127:0] num;
      logic [127:0] q;
      num = 128'(mag) * 128'(64'd45873289113781267);
      q = num / den;
      if (q > 128'h1000000000000) q = 128'h1000000000000;
      if (neg) begin
        if (q > 128'h800000000000) q = 128'h800000000000;
        return 48'(-q);
      end
      return (q > 128'h7FFFFFFFFFFF) ? 48'h7FFFFFFFFFFF : q[47:0];
    endfunction

    function void note_pair(logic [191:0] pair);
      logic signed [33:0] r[3];
      logic [63:0] mag[3];
      logic [63:0] sq[3];
      logic [63:0] r2, d, m;
      logic [127:0] den;
      tensor_t t;
      int pa[3];
      int pb[3];
      logic [47:0] offs[3];
      pa = '{0, 0, 1};
      pb = '{1, 2, 2};
      r2 = 0;
      for (int i = 0; i < 3; i++) begin
        r[i] = 34'(signed'(pair[32*i +: 32])) - 34'(signed'(pair[32*(i+3) +: 32]));
        mag[i] = (r[i] < 0) ? 64'(-r[i]) : 64'(r[i]);
        sq[i] = (mag[i] * mag[i]) >> 12;
        r2 = r2 + sq[i];
      end
      d = r2 + 64'(eps2);
      if (d == 0) begin
        t.xx = 48'h7FFFFFFFFFFF;
        t.yy = 48'h7FFFFFFFFFFF;
        t.zz = 48'h7FFFFFFFFFFF;
        t.xy = 0;
        t.xz = 0;
        t.yz = 0;
      end else begin
        den = (128'(d) * 128'(root64(d << 10))) << 7;
        t.xx = entry_of(r2 + 2 * 64'(eps2) + sq[0], 0, den);
        t.yy = entry_of(r2 + 2 * 64'(eps2) + sq[1], 0, den);
        t.zz = entry_of(r2 + 2 * 64'(eps2) + sq[2], 0, den);
        for (int i = 0; i < 3; i++) begin
          m = (mag[pa[i]] * mag[pb[i]]) >> 12;
          offs[i] = (m == 0) ? 48'd0 :
                    entry_of(m, (r[pa[i]] < 0) != (r[pb[i]] < 0), den);
        end
        t.xy = offs[0];
        t.xz = offs[1];
        t.yz = offs[2];
      end
      pending.push_back(t);
    endfunction

    function void check_result(logic [287:0] data);
      tensor_t got, exp;
      got = data;
      if (pending.size() == 0) begin
        $error("unexpected result %h", data);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.xx !== exp.xx) begin $error("s_xx exp %h got %h", exp.xx, got.xx); errors++; end
      if (got.yy !== exp.yy) begin $error("s_yy exp %h got %h", exp.yy, got.yy); errors++; end
      if (got.zz !== exp.zz) begin $error("s_zz exp %h got %h", exp.zz, got.zz); errors++; end
      if (got.xy !== exp.xy) begin $error("s_xy exp %h got %h", exp.xy, got.xy); errors++; end
      if (got.xz !== exp.xz) begin $error("s_xz exp %h got %h", exp.xz, got.xz); errors++; end
      if (got.yz !== exp.yz) begin $error("s_yz exp %h got %h", exp.yz, got.yz); errors++; end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [191:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [287:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [47:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  tensor_scoreboard board = new();

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  regularized_stokeslet_block uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_pair(logic [191:0] pair);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= pair;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_pair(pair);
  endtask

  task automatic write_eps(logic [47:0] value);
    cfg_valid <= 1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.eps2 = value;
    cfg_valid <= 0;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h8000_0000 ^ $urandom_range(3);
      2: return 32'h7FFF_FFFF - $urandom_range(3);
      3: return 32'($urandom_range(2047)) - 32'd1024;
      default: return 32'(signed'(32'($urandom)) >>> $urandom_range(28));
    endcase
  endfunction

  function automatic logic [191:0] rand_pair();
    logic [191:0] p;
    for (int i = 0; i < 6; i++) p[32*i +: 32] = rand_coord();
    // Near-coincident points exercise the regularized core.
    if ($urandom_range(3) == 0)
      for (int i = 0; i < 3; i++)
        p[32*(i+3) +: 32] = p[32*i +: 32] + 32'($urandom_range(64)) - 32'd32;
    return p;
  endfunction

  task automatic directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7FFF_FFFF;
    send_pair('0);
    send_pair({mn, mn, mn, mx, mx, mx});
    send_pair({mx, mx, mx, mn, mn, mn});
    send_pair({mn, mx, mn, mx, mn, mx});
    send_pair({32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0});
    send_pair({32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0});
    send_pair({32'd3, 32'd5, 32'd7, 32'd0, 32'd0, 32'd0});
    send_pair({32'h4000_0000, 32'hC000_0000, 32'h0000_1000, 32'd0, 32'd0, 32'd0});
    send_pair({32'd0, 32'd0, 32'd0, 32'h0000_1000, 32'hFFFF_F000, 32'h0000_0800});
    send_pair({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0});
    send_pair({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
               32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
  endtask

  task automatic random_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_pair(rand_pair());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    drain();
    write_eps(48'd0);
    directed();
    drain();
    write_eps(48'hFFFF_FFFF_FFFF);
    directed();
    random_phase(150, 0, 0);
    drain();
    write_eps(48'd1);
    random_phase(200, 58, 0);
    drain();
    write_eps(48'($urandom) << 16 | 48'($urandom_range(65535)));
    random_phase(200, 0, 58);
    drain();
    write_eps(48'd0);
    random_phase(200, 11, 11);
    drain();
    for (int k = 0; k < 4; k++) begin
      write_eps({16'($urandom), 32'($urandom)} >> $urandom_range(47));
      random_phase(200, 0, 0);
      random_phase(25, 58, 58);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/rsb_pkg.sv
rtl/rsb_front.sv
rtl/rsb_sqrt.sv
rtl/rsb_mul.sv
rtl/rsb_div.sv
rtl/regularized_stokeslet_block.sv
tb/sv/regularized_stokeslet_block_tb.sv
